### rtl/unified_hunk_parser_macros.svh
// Assertion macros shared by the unified hunk parser RTL.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef UNIFIED_HUNK_PARSER_MACROS_SVH
`define UNIFIED_HUNK_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define UHP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define UHP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/uhp_pkg.sv
// Shared types and codes of the unified hunk parser.
// No dependencies; imported by uhp_core, uhp_rsp_fifo, unified_hunk_parser and the testbench.
package uhp_pkg;

   // default upper bound for a range count
   localparam int unsigned UHP_MAX_COUNT = 65535;

   // result queue depth: room for two results per transaction plus slack
   localparam int unsigned RSP_DEPTH = 4;

   // result kinds
   localparam logic [2:0] KIND_BEFORE = 3'd0;
   localparam logic [2:0] KIND_AFTER  = 3'd1;
   localparam logic [2:0] KIND_BOTH   = 3'd2;
   localparam logic [2:0] KIND_ACCEPT = 3'd3;
   localparam logic [2:0] KIND_ERROR  = 3'd4;

   // error codes
   localparam logic [3:0] ERR_BAD_LITERAL   = 4'd0;
   localparam logic [3:0] ERR_UNTERMINATED  = 4'd1;
   localparam logic [3:0] ERR_COUNT_BIG     = 4'd2;
   localparam logic [3:0] ERR_MISSING_COUNT = 4'd3;
   localparam logic [3:0] ERR_INCOMPLETE    = 4'd4;
   localparam logic [3:0] ERR_MISPLACED     = 4'd5;
   localparam logic [3:0] ERR_BAD_KIND      = 4'd6;
   localparam logic [3:0] ERR_OLD_LENGTH    = 4'd7;
   localparam logic [3:0] ERR_NEW_LENGTH    = 4'd8;
   localparam logic [3:0] ERR_TRUNCATED     = 4'd9;

   // one result transaction
   typedef struct packed {
      logic [2:0] result_kind;
      logic [7:0] data_byte;
      logic [3:0] error_code;
      logic       run_end;
   } rsp_item_type;

   // results produced by one parsed byte, in order
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

### rtl/unified_hunk_parser.sv
// Unified single-hunk patch parser: one patch byte per transaction in, routed bytes out.
// An accepted byte reaches its first result through the input register and then the result queue.
// Throughput: one byte per cycle; the input stalls only while more than two results wait in
// the four-entry result queue, which needs the result side to stall.
// Reset: synchronous, clears parser state, the input valid flag and the queue pointers; no clearing pass.
// Depends on uhp_pkg, uhp_core and uhp_rsp_fifo.
module unified_hunk_parser #(
   parameter int unsigned MAX_COUNT = uhp_pkg::UHP_MAX_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_patch_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_result_kind,
   output logic [7:0] rsp_data_byte,
   output logic [3:0] rsp_error_code,
   output logic       rsp_run_end
);
   import uhp_pkg::*;

   localparam int unsigned LevelW = $clog2(RSP_DEPTH + 1);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic              advance;
   logic              req_take;
   logic [LevelW-1:0] level;
   push_type          push;
   rsp_item_type      rsp_item;

   // parse the held byte only when the queue has room for two results
   assign advance   = in_valid_ff && (level <= LevelW'(RSP_DEPTH - 2));
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // hold the incoming transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_patch_byte;
         in_last_ff <= req_last_byte;
      end
   end

   uhp_core #(
      .MAX_COUNT (MAX_COUNT)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .patch_byte (in_byte_ff),
      .last_byte  (in_last_ff),
      .push       (push)
   );

   uhp_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .level     (level)
   );

   assign rsp_result_kind = rsp_item.result_kind;
   assign rsp_data_byte   = rsp_item.data_byte;
   assign rsp_error_code  = rsp_item.error_code;
   assign rsp_run_end     = rsp_item.run_end;

endmodule

### rtl/uhp_core.sv
// Byte-level parser state and next-state logic of the unified hunk parser.
// Depends on uhp_pkg and unified_hunk_parser_macros.svh.
`include "unified_hunk_parser_macros.svh"

module uhp_core #(
   parameter int unsigned MAX_COUNT = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [7:0]        patch_byte,
   input  logic              last_byte,
   output uhp_pkg::push_type push
);
   import uhp_pkg::*;

   localparam int unsigned CountW = $clog2(MAX_COUNT + 1);
   localparam int unsigned WideW  = CountW + 4;
   localparam logic [WideW-1:0] MaxWide = WideW'(MAX_COUNT);

   // header literals and the no-newline marker
   localparam logic [8*4-1:0]  TXT_MINUS = "--- ";
   localparam logic [8*4-1:0]  TXT_PLUS  = "+++ ";
   localparam logic [8*4-1:0]  TXT_HUNK  = "@@ -";
   localparam logic [8*2-1:0]  TXT_MID   = " +";
   localparam logic [8*4-1:0]  TXT_TAIL  = " @@\n";
   localparam logic [8*28-1:0] TXT_MARK  = "\\ No newline at end of file\n";
   localparam logic [4:0]      MARK_LEN  = 5'd28;

   localparam logic [7:0] CH_NL        = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   // line kinds; held newline uses the same codes
   localparam logic [1:0] LK_NONE  = 2'd0;
   localparam logic [1:0] LK_MINUS = 2'd1;
   localparam logic [1:0] LK_PLUS  = 2'd2;
   localparam logic [1:0] LK_BOTH  = 2'd3;

   // budget fault of the current line
   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_OLD  = 2'd1;
   localparam logic [1:0] FAULT_NEW  = 2'd2;

   typedef enum logic [3:0] {
      PH_LIT_MINUS,
      PH_LINE1,
      PH_LIT_PLUS,
      PH_LINE2,
      PH_LIT_HUNK,
      PH_OLD_START,
      PH_OLD_COUNT,
      PH_LIT_MID,
      PH_NEW_START,
      PH_NEW_COUNT,
      PH_LIT_TAIL,
      PH_BODY_START,
      PH_BODY_LINE,
      PH_MARKER
   } phase_type;

   typedef struct packed {
      logic              bad;
      logic [3:0]        code;
      logic [CountW-1:0] count;
   } close_type;

   phase_type         phase_ff, phase_in;
   logic [4:0]        lit_idx_ff, lit_idx_in;
   logic [CountW-1:0] num_ff, num_in;
   logic [CountW-1:0] rstart_ff, rstart_in;
   logic              seen_ff, seen_in;
   logic [CountW-1:0] old_rem_ff, old_rem_in;
   logic [CountW-1:0] new_rem_ff, new_rem_in;
   logic              old_closed_ff, old_closed_in;
   logic              new_closed_ff, new_closed_in;
   logic [1:0]        prev_kind_ff, prev_kind_in;
   logic [1:0]        held_ff, held_in;
   logic [1:0]        fault_ff, fault_in;
   logic              stopped_ff, stopped_in;

   // expected literal byte at a position
   function automatic logic [7:0] lit_char(phase_type ph, logic [4:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      case (ph)
         PH_LIT_MINUS: ch = TXT_MINUS[{~idx[1:0], 3'b000} +: 8];
         PH_LIT_PLUS:  ch = TXT_PLUS[{~idx[1:0], 3'b000} +: 8];
         PH_LIT_HUNK:  ch = TXT_HUNK[{~idx[1:0], 3'b000} +: 8];
         PH_LIT_MID:   ch = TXT_MID[{~idx[0], 3'b000} +: 8];
         PH_LIT_TAIL:  ch = TXT_TAIL[{~idx[1:0], 3'b000} +: 8];
         default: begin
            if (idx < MARK_LEN) begin
               ch = TXT_MARK[{5'd27 - idx, 3'b000} +: 8];
            end
         end
      endcase
      return ch;
   endfunction

   function automatic logic [4:0] lit_len(phase_type ph);
      logic [4:0] len;
      case (ph)
         PH_LIT_MINUS, PH_LIT_PLUS, PH_LIT_HUNK, PH_LIT_TAIL: len = 5'd4;
         PH_LIT_MID: len = 5'd2;
         default:    len = MARK_LEN;
      endcase
      return len;
   endfunction

   function automatic phase_type lit_next(phase_type ph);
      phase_type nx;
      case (ph)
         PH_LIT_MINUS: nx = PH_LINE1;
         PH_LIT_PLUS:  nx = PH_LINE2;
         PH_LIT_HUNK:  nx = PH_OLD_START;
         PH_LIT_MID:   nx = PH_NEW_START;
         default:      nx = PH_BODY_START;
      endcase
      return nx;
   endfunction

   // validate a finished range: start 0 with count 0, or start 1 with count > 0
   function automatic close_type close_check(phase_type ph, logic [CountW-1:0] num,
                                             logic [CountW-1:0] rstart, logic seen);
      close_type         cr;
      logic [CountW-1:0] start_v;
      logic              ok;
      if (ph == PH_OLD_START || ph == PH_NEW_START) begin
         start_v  = num;
         cr.count = CountW'(1);
      end else begin
         start_v  = rstart;
         cr.count = num;
      end
      ok = (cr.count == '0 && start_v == '0) ||
           (cr.count != '0 && start_v == CountW'(1));
      cr.bad  = !seen || !ok;
      cr.code = !seen ? ERR_MISSING_COUNT : ERR_INCOMPLETE;
      return cr;
   endfunction

   // parse one byte and collect its results
   always_comb begin
      close_type    cr;
      logic [WideW-1:0] prod;
      logic [4:0]   len;
      logic         err;
      logic [3:0]   code;
      logic         c_put;
      rsp_item_type c_item;
      logic         f_flush;
      logic [1:0]   fl_kind;
      logic         f_accept;
      logic [1:0]   pk;
      logic [1:0]   n;
      rsp_item_type slot0, slot1, item;

      phase_in      = phase_ff;
      lit_idx_in    = lit_idx_ff;
      num_in        = num_ff;
      rstart_in     = rstart_ff;
      seen_in       = seen_ff;
      old_rem_in    = old_rem_ff;
      new_rem_in    = new_rem_ff;
      old_closed_in = old_closed_ff;
      new_closed_in = new_closed_ff;
      prev_kind_in  = prev_kind_ff;
      held_in       = held_ff;
      fault_in      = fault_ff;
      stopped_in    = stopped_ff;

      cr       = '0;
      prod     = ({4'b0000, num_ff} << 3) + ({4'b0000, num_ff} << 1)
                 + WideW'(patch_byte[3:0]);
      len      = lit_len(phase_ff);
      err      = 1'b0;
      code     = ERR_BAD_LITERAL;
      c_put    = 1'b0;
      c_item   = '0;
      f_flush  = 1'b0;
      fl_kind  = LK_NONE;
      f_accept = 1'b0;
      pk       = LK_NONE;
      n        = 2'd0;
      slot0    = '0;
      slot1    = '0;
      item     = '0;

      if (advance && !stopped_ff) begin
         // consume the byte
         case (phase_ff)
            PH_LINE1, PH_LINE2: begin
               if (patch_byte == CH_NL) begin
                  phase_in   = (phase_ff == PH_LINE1) ? PH_LIT_PLUS : PH_LIT_HUNK;
                  lit_idx_in = '0;
               end
            end
            PH_OLD_START, PH_OLD_COUNT, PH_NEW_START, PH_NEW_COUNT: begin
               if (patch_byte inside {[CH_ZERO:CH_NINE]}) begin
                  if (prod > MaxWide) begin
                     err  = 1'b1;
                     code = ERR_COUNT_BIG;
                  end else begin
                     num_in  = prod[CountW-1:0];
                     seen_in = 1'b1;
                  end
               end else if (patch_byte == CH_COMMA &&
                            (phase_ff == PH_OLD_START || phase_ff == PH_NEW_START)) begin
                  if (!seen_ff) begin
                     err  = 1'b1;
                     code = ERR_MISSING_COUNT;
                  end else begin
                     rstart_in = num_ff;
                     num_in    = '0;
                     seen_in   = 1'b0;
                     phase_in  = (phase_ff == PH_OLD_START) ? PH_OLD_COUNT : PH_NEW_COUNT;
                  end
               end else begin
                  // close the range; the byte must open the following literal
                  cr = close_check(phase_ff, num_ff, rstart_ff, seen_ff);
                  if (cr.bad) begin
                     err  = 1'b1;
                     code = cr.code;
                  end else if (patch_byte != CH_SPACE) begin
                     err  = 1'b1;
                     code = ERR_BAD_LITERAL;
                  end else begin
                     lit_idx_in = 5'd1;
                     if (phase_ff == PH_NEW_START || phase_ff == PH_NEW_COUNT) begin
                        new_rem_in = cr.count;
                        phase_in   = PH_LIT_TAIL;
                     end else begin
                        old_rem_in = cr.count;
                        phase_in   = PH_LIT_MID;
                     end
                  end
               end
            end
            PH_BODY_START: begin
               if (patch_byte == CH_BACKSLASH) begin
                  if (prev_kind_ff == LK_NONE) begin
                     err  = 1'b1;
                     code = ERR_MISPLACED;
                  end else begin
                     held_in = LK_NONE;
                     if (prev_kind_ff != LK_PLUS) begin
                        old_closed_in = 1'b1;
                     end
                     if (prev_kind_ff != LK_MINUS) begin
                        new_closed_in = 1'b1;
                     end
                     prev_kind_in = LK_NONE;
                     phase_in     = PH_MARKER;
                     lit_idx_in   = 5'd1;
                  end
               end else if (patch_byte != CH_MINUS && patch_byte != CH_PLUS &&
                            patch_byte != CH_SPACE) begin
                  err  = 1'b1;
                  code = ERR_BAD_KIND;
               end else begin
                  // release the previous line's newline
                  if (held_ff != LK_NONE) begin
                     c_put              = 1'b1;
                     c_item.result_kind = {1'b0, held_ff - 2'd1};
                     c_item.data_byte   = CH_NL;
                  end
                  held_in = LK_NONE;
                  pk = (patch_byte == CH_MINUS) ? LK_MINUS :
                       (patch_byte == CH_PLUS)  ? LK_PLUS  : LK_BOTH;
                  prev_kind_in = pk;
                  fault_in     = FAULT_NONE;
                  if (pk != LK_PLUS && (old_closed_ff || old_rem_ff == '0)) begin
                     fault_in = FAULT_OLD;
                  end else if (pk != LK_MINUS && (new_closed_ff || new_rem_ff == '0)) begin
                     fault_in = FAULT_NEW;
                  end else begin
                     if (pk != LK_PLUS) begin
                        old_rem_in = old_rem_ff - CountW'(1);
                     end
                     if (pk != LK_MINUS) begin
                        new_rem_in = new_rem_ff - CountW'(1);
                     end
                  end
                  phase_in = PH_BODY_LINE;
               end
            end
            PH_BODY_LINE: begin
               if (patch_byte == CH_NL) begin
                  if (fault_ff != FAULT_NONE) begin
                     err  = 1'b1;
                     code = (fault_ff == FAULT_OLD) ? ERR_OLD_LENGTH : ERR_NEW_LENGTH;
                  end else begin
                     held_in  = prev_kind_ff;
                     phase_in = PH_BODY_START;
                  end
               end else if (fault_ff == FAULT_NONE) begin
                  c_put              = 1'b1;
                  c_item.result_kind = {1'b0, prev_kind_ff - 2'd1};
                  c_item.data_byte   = patch_byte;
               end
            end
            default: begin
               // literal match
               if (lit_idx_ff >= len || lit_char(phase_ff, lit_idx_ff) != patch_byte) begin
                  err  = 1'b1;
                  code = ERR_BAD_LITERAL;
               end else if (lit_idx_ff + 5'd1 == len) begin
                  lit_idx_in = '0;
                  phase_in   = lit_next(phase_ff);
                  num_in     = '0;
                  seen_in    = 1'b0;
                  if (lit_next(phase_ff) == PH_BODY_START) begin
                     prev_kind_in = LK_NONE;
                  end
               end else begin
                  lit_idx_in = lit_idx_ff + 5'd1;
               end
            end
         endcase

         // end of patch
         if (!err && last_byte) begin
            case (phase_in)
               PH_LINE1, PH_LINE2, PH_BODY_LINE: begin
                  err  = 1'b1;
                  code = ERR_UNTERMINATED;
               end
               PH_OLD_START, PH_OLD_COUNT, PH_NEW_START, PH_NEW_COUNT: begin
                  cr   = close_check(phase_in, num_in, rstart_in, seen_in);
                  err  = 1'b1;
                  code = cr.bad ? cr.code : ERR_BAD_LITERAL;
               end
               PH_BODY_START: begin
                  if (old_rem_in != '0 || new_rem_in != '0) begin
                     err  = 1'b1;
                     code = ERR_TRUNCATED;
                  end else begin
                     f_flush    = (held_in != LK_NONE);
                     fl_kind    = held_in - 2'd1;
                     held_in    = LK_NONE;
                     f_accept   = 1'b1;
                     stopped_in = 1'b1;
                  end
               end
               default: begin
                  err  = 1'b1;
                  code = ERR_BAD_LITERAL;
               end
            endcase
         end

         if (err) begin
            stopped_in = 1'b1;
         end

         // collect results in order
         if (c_put) begin
            slot0 = c_item;
            n     = 2'd1;
         end
         if (f_flush) begin
            item             = '0;
            item.result_kind = {1'b0, fl_kind};
            item.data_byte   = CH_NL;
            if (n == 2'd0) begin
               slot0 = item;
            end else begin
               slot1 = item;
            end
            n = n + 2'd1;
         end
         if (f_accept || err) begin
            item             = '0;
            item.result_kind = err ? KIND_ERROR : KIND_ACCEPT;
            item.error_code  = err ? code : 4'd0;
            if (n == 2'd0) begin
               slot0 = item;
            end else begin
               slot1 = item;
            end
            n = n + 2'd1;
         end
         if (n == 2'd1) begin
            slot0.run_end = 1'b1;
         end
         if (n == 2'd2) begin
            slot1.run_end = 1'b1;
         end
      end

      push.count  = n;
      push.first  = slot0;
      push.second = slot1;
   end

   // hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LIT_MINUS;
         lit_idx_ff    <= '0;
         num_ff        <= '0;
         rstart_ff     <= '0;
         seen_ff       <= 1'b0;
         old_rem_ff    <= '0;
         new_rem_ff    <= '0;
         old_closed_ff <= 1'b0;
         new_closed_ff <= 1'b0;
         prev_kind_ff  <= LK_NONE;
         held_ff       <= LK_NONE;
         fault_ff      <= FAULT_NONE;
         stopped_ff    <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         lit_idx_ff    <= lit_idx_in;
         num_ff        <= num_in;
         rstart_ff     <= rstart_in;
         seen_ff       <= seen_in;
         old_rem_ff    <= old_rem_in;
         new_rem_ff    <= new_rem_in;
         old_closed_ff <= old_closed_in;
         new_closed_ff <= new_closed_in;
         prev_kind_ff  <= prev_kind_in;
         held_ff       <= held_in;
         fault_ff      <= fault_in;
         stopped_ff    <= stopped_in;
      end
   end

   `UHP_ASSERT_IMPL(a_silent_when_stopped, stopped_ff, push.count == 2'd0, "result after stop")
   `UHP_ASSERT_IMPL(a_run_end_on_last, push.count != 2'd0,
      (push.count == 2'd1 && push.first.run_end) ||
      (push.count == 2'd2 && push.second.run_end && !push.first.run_end),
      "run_end not on final result")
   `UHP_ASSERT_IMPL(a_stop_needs_byte, $rose(stopped_ff), $past(advance),
      "parser stopped without a byte")

endmodule

### rtl/uhp_rsp_fifo.sv
// Small result queue of the unified hunk parser: takes up to two results a cycle.
// Depends on uhp_pkg.
module uhp_rsp_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  uhp_pkg::push_type               push,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output uhp_pkg::rsp_item_type           rsp_item,
   output logic [$clog2(DEPTH+1)-1:0]      level
);
   import uhp_pkg::*;

   localparam int unsigned PtrW   = $clog2(DEPTH);
   localparam int unsigned LevelW = $clog2(DEPTH + 1);

   rsp_item_type      mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ff, wr_in;
   logic [PtrW-1:0]   rd_ff, rd_in;
   logic [LevelW-1:0] level_ff, level_in;
   logic              pop;

   // advance pointers and occupancy
   always_comb begin
      pop      = rsp_valid && !rsp_stall;
      wr_in    = wr_ff + PtrW'(push.count);
      rd_in    = rd_ff + PtrW'(pop);
      level_in = level_ff + LevelW'(push.count) - LevelW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   // store results in arrival order
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + PtrW'(1)] <= push.second;
      end
   end

   assign rsp_valid = (level_ff != '0);
   assign rsp_item  = mem_ff[rd_ff];
   assign level     = level_ff;

endmodule

### test/tb_unified_hunk_parser.sv
`timescale 1ns / 1ps
// Self-checking bench for unified_hunk_parser: streams one generated single-hunk patch
// through the request channel and checks every result against a local parser model.
// Depends on uhp_pkg and the unified_hunk_parser RTL.
module tb_unified_hunk_parser;
   import uhp_pkg::*;

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 20;
   localparam int BODY_BYTES    = 1080;
   localparam int TRAIL_ITEMS   = 30;
   localparam int LONG_HOLD     = 80;
   localparam int HOLD_AFTER    = 150;
   localparam int NO_FAULT      = -1;
   localparam int DEC_BASE      = 10;

   localparam logic [3:0] NO_CODE   = 4'd0;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam string MINUS_TEXT  = "--- ";
   localparam string PLUS_TEXT   = "+++ ";
   localparam string HUNK_TEXT   = "@@ -";
   localparam string MID_TEXT    = " +";
   localparam string TAIL_TEXT   = " @@\n";
   localparam string MARKER_TEXT = "\\ No newline at end of file\n";

   // line kinds as the parser tracks them
   localparam logic [1:0] LK_NONE = 2'd0;
   localparam logic [1:0] LK_OLD  = 2'd1;
   localparam logic [1:0] LK_NEW  = 2'd2;
   localparam logic [1:0] LK_BOTH = 2'd3;

   // which budget a body line broke
   localparam logic [1:0] LF_NONE = 2'd0;
   localparam logic [1:0] LF_OLD  = 2'd1;
   localparam logic [1:0] LF_NEW  = 2'd2;

   typedef enum logic [3:0] {
      PH_LIT_MINUS, PH_LINE1, PH_LIT_PLUS, PH_LINE2, PH_LIT_HUNK,
      PH_OLD_START, PH_OLD_COUNT, PH_LIT_MID, PH_NEW_START, PH_NEW_COUNT,
      PH_LIT_TAIL, PH_BODY_START, PH_BODY_LINE, PH_MARKER
   } parse_phase_type;

   typedef enum int {
      END_ACCEPT, END_MARKERS, END_TRUNCATED, END_OVERLONG,
      END_UNTERMINATED, END_BAD_KIND, END_MISPLACED, END_AFTER_MARKER
   } ending_type;

   typedef enum int {FLAVOR_MIXED, FLAVOR_ADD, FLAVOR_DELETE} flavor_type;

   typedef struct packed {
      logic [7:0] patch_byte;
      logic       last_byte;
   } patch_item_type;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_patch_byte = 8'h00;
   logic       req_last_byte  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [2:0] rsp_result_kind;
   logic [7:0] rsp_data_byte;
   logic [3:0] rsp_error_code;
   logic       rsp_run_end;

   unified_hunk_parser uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_patch_byte  (req_patch_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_error_code  (rsp_error_code),
      .rsp_run_end     (rsp_run_end)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Hunk parser model: state after reset, stepped once per accepted byte
   // ---------------------------------------------------------------------------------------
   parse_phase_type hp_phase       = PH_LIT_MINUS;
   int unsigned     hp_lit_idx     = 0;
   logic [15:0]     hp_number      = '0;
   logic [15:0]     hp_range_start = '0;
   logic [15:0]     hp_old_left    = '0;
   logic [15:0]     hp_new_left    = '0;
   logic            hp_digit_seen  = 1'b0;
   logic            hp_old_closed  = 1'b0;
   logic            hp_new_closed  = 1'b0;
   logic            hp_stopped     = 1'b0;
   logic [1:0]      hp_prev_kind   = LK_NONE;
   logic [1:0]      hp_held_nl     = LK_NONE;
   logic [1:0]      hp_len_fault   = LF_NONE;

   rsp_item_type awaited_results[$];
   int           step_results;

   function automatic logic [2:0] line_result_kind(logic [1:0] k);
      case (k)
         LK_OLD:  return KIND_BEFORE;
         LK_NEW:  return KIND_AFTER;
         default: return KIND_BOTH;
      endcase
   endfunction

   function automatic void emit(logic [2:0] kind, logic [7:0] data, logic [3:0] code);
      rsp_item_type r;
      r.result_kind = kind;
      r.data_byte   = data;
      r.error_code  = code;
      r.run_end     = 1'b0;
      awaited_results.push_back(r);
      step_results++;
   endfunction

   // send the newline held back from the previous body line
   function automatic void release_newline();
      if (hp_held_nl != LK_NONE) begin
         emit(line_result_kind(hp_held_nl), CH_NL, NO_CODE);
         hp_held_nl = LK_NONE;
      end
   endfunction

   function automatic int match_literal(logic [7:0] b);
      string           lit;
      parse_phase_type after_lit;
      case (hp_phase)
         PH_LIT_MINUS: begin lit = MINUS_TEXT;  after_lit = PH_LINE1;      end
         PH_LIT_PLUS:  begin lit = PLUS_TEXT;   after_lit = PH_LINE2;      end
         PH_LIT_HUNK:  begin lit = HUNK_TEXT;   after_lit = PH_OLD_START;  end
         PH_LIT_MID:   begin lit = MID_TEXT;    after_lit = PH_NEW_START;  end
         PH_LIT_TAIL:  begin lit = TAIL_TEXT;   after_lit = PH_BODY_START; end
         default:      begin lit = MARKER_TEXT; after_lit = PH_BODY_START; end
      endcase
      if (hp_lit_idx >= lit.len() || lit[hp_lit_idx] != b) return ERR_BAD_LITERAL;
      hp_lit_idx++;
      if (hp_lit_idx == lit.len()) begin
         hp_lit_idx    = 0;
         hp_phase      = after_lit;
         hp_number     = '0;
         hp_digit_seen = 1'b0;
         if (after_lit == PH_BODY_START) hp_prev_kind = LK_NONE;
      end
      return NO_FAULT;
   endfunction

   // finish a range: start 0 with count 0, or start 1 with a nonzero count
   function automatic int close_range();
      logic [15:0] range_first;
      logic [15:0] range_span;
      logic        is_new;
      is_new = (hp_phase == PH_NEW_START || hp_phase == PH_NEW_COUNT);
      if (!hp_digit_seen) return ERR_MISSING_COUNT;
      if (hp_phase == PH_OLD_START || hp_phase == PH_NEW_START) begin
         range_first = hp_number;
         range_span  = 16'd1;
      end else begin
         range_first = hp_range_start;
         range_span  = hp_number;
      end
      if (!((range_span == 0 && range_first == 0) || (range_span != 0 && range_first == 1)))
         return ERR_INCOMPLETE;
      if (is_new) begin
         hp_new_left = range_span;
         hp_phase    = PH_LIT_TAIL;
      end else begin
         hp_old_left = range_span;
         hp_phase    = PH_LIT_MID;
      end
      hp_lit_idx = 0;
      return NO_FAULT;
   endfunction

   function automatic int take_byte(logic [7:0] b);
      int unsigned acc;
      int          fault;
      case (hp_phase)
         PH_LINE1, PH_LINE2: begin
            if (b == CH_NL) begin
               hp_phase   = (hp_phase == PH_LINE1) ? PH_LIT_PLUS : PH_LIT_HUNK;
               hp_lit_idx = 0;
            end
            return NO_FAULT;
         end
         PH_OLD_START, PH_OLD_COUNT, PH_NEW_START, PH_NEW_COUNT: begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
               acc = 32'(hp_number) * DEC_BASE + 32'(b - CH_ZERO);
               if (acc > UHP_MAX_COUNT) return ERR_COUNT_BIG;
               hp_number     = acc[15:0];
               hp_digit_seen = 1'b1;
               return NO_FAULT;
            end
            if (b == CH_COMMA && (hp_phase == PH_OLD_START || hp_phase == PH_NEW_START)) begin
               if (!hp_digit_seen) return ERR_MISSING_COUNT;
               hp_range_start = hp_number;
               hp_number      = '0;
               hp_digit_seen  = 1'b0;
               hp_phase       = (hp_phase == PH_OLD_START) ? PH_OLD_COUNT : PH_NEW_COUNT;
               return NO_FAULT;
            end
            fault = close_range();
            if (fault != NO_FAULT) return fault;
            return match_literal(b);
         end
         PH_BODY_START: begin
            // no-newline marker: drop the held newline and close the side(s) just used
            if (b == CH_BSLASH) begin
               if (hp_prev_kind == LK_NONE) return ERR_MISPLACED;
               hp_held_nl = LK_NONE;
               if (hp_prev_kind != LK_NEW) hp_old_closed = 1'b1;
               if (hp_prev_kind != LK_OLD) hp_new_closed = 1'b1;
               hp_prev_kind = LK_NONE;
               hp_phase     = PH_MARKER;
               hp_lit_idx   = 1;
               return NO_FAULT;
            end
            if (b != CH_DASH && b != CH_PLUS && b != CH_SPACE) return ERR_BAD_KIND;
            release_newline();
            hp_prev_kind = (b == CH_DASH) ? LK_OLD : (b == CH_PLUS) ? LK_NEW : LK_BOTH;
            hp_len_fault = LF_NONE;
            // charge the budgets, old side first
            if (hp_prev_kind != LK_NEW && (hp_old_closed || hp_old_left == 0))
               hp_len_fault = LF_OLD;
            else if (hp_prev_kind != LK_OLD && (hp_new_closed || hp_new_left == 0))
               hp_len_fault = LF_NEW;
            else begin
               if (hp_prev_kind != LK_NEW) hp_old_left--;
               if (hp_prev_kind != LK_OLD) hp_new_left--;
            end
            hp_phase = PH_BODY_LINE;
            return NO_FAULT;
         end
         PH_BODY_LINE: begin
            if (b == CH_NL) begin
               if (hp_len_fault == LF_OLD) return ERR_OLD_LENGTH;
               if (hp_len_fault == LF_NEW) return ERR_NEW_LENGTH;
               hp_held_nl = hp_prev_kind;
               hp_phase   = PH_BODY_START;
               return NO_FAULT;
            end
            if (hp_len_fault == LF_NONE) emit(line_result_kind(hp_prev_kind), b, NO_CODE);
            return NO_FAULT;
         end
         default: return match_literal(b);
      endcase
   endfunction

   // end of patch reached after the byte marked last
   function automatic int close_patch();
      int fault;
      case (hp_phase)
         PH_LINE1, PH_LINE2, PH_BODY_LINE: return ERR_UNTERMINATED;
         PH_OLD_START, PH_OLD_COUNT, PH_NEW_START, PH_NEW_COUNT: begin
            fault = close_range();
            return (fault != NO_FAULT) ? fault : ERR_BAD_LITERAL;
         end
         PH_BODY_START: begin
            if (hp_old_left != 0 || hp_new_left != 0) return ERR_TRUNCATED;
            release_newline();
            emit(KIND_ACCEPT, 8'h00, NO_CODE);
            hp_stopped = 1'b1;
            return NO_FAULT;
         end
         default: return ERR_BAD_LITERAL;
      endcase
   endfunction

   function automatic void route_patch_byte(logic [7:0] b, logic last);
      int           fault;
      rsp_item_type closing;
      step_results = 0;
      if (hp_stopped) return;
      fault = take_byte(b);
      if (fault == NO_FAULT && last) fault = close_patch();
      if (fault != NO_FAULT) begin
         emit(KIND_ERROR, 8'h00, 4'(fault));
         hp_stopped = 1'b1;
      end
      // flag the final result of this byte
      if (step_results > 0) begin
         closing         = awaited_results.pop_back();
         closing.run_end = 1'b1;
         awaited_results.push_back(closing);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Patch text generation
   // ---------------------------------------------------------------------------------------
   logic [7:0] patch_text[$];
   int         old_line_total = 0;
   int         new_line_total = 0;

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) patch_text.push_back(s[i]);
   endfunction

   // any byte except a newline
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 254));
      if (b >= CH_NL) b++;
      return b;
   endfunction

   function automatic int line_length();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
   endfunction

   function automatic void put_line(logic [7:0] kind, int len);
      patch_text.push_back(kind);
      for (int i = 0; i < len; i++) patch_text.push_back(plain_byte());
      patch_text.push_back(CH_NL);
      if (kind != CH_PLUS) old_line_total++;
      if (kind != CH_DASH) new_line_total++;
   endfunction

   function automatic void put_range(int n);
      if (n == 0) put_text("0,0");
      else if (n == 1 && $urandom_range(0, 1) == 1) put_text("1");
      else begin
         if ($urandom_range(0, 3) == 0) put_text("01,");
         else put_text("1,");
         put_text($sformatf("%0d", n));
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driver: bursts of transactions with random gaps, one pause to drain all results
   // ---------------------------------------------------------------------------------------
   patch_item_type patch_bytes_q[$];
   int bytes_accepted = 0;
   int items_loaded   = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   int drain_at       = -1;

   always @(posedge clock) begin
      patch_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // retire the transaction taken at this edge
         if (req_valid && !req_stall) begin
            route_patch_byte(req_patch_byte, req_last_byte);
            bytes_accepted++;
         end
         // load the next byte unless the current one is held
         if (!req_valid || !req_stall) begin
            if (items_loaded == drain_at && awaited_results.size() != 0) begin
               req_valid <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (patch_bytes_q.size() != 0) begin
               item = patch_bytes_q.pop_front();
               req_valid      <= 1'b1;
               req_patch_byte <= item.patch_byte;
               req_last_byte  <= item.last_byte;
               items_loaded++;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver stall pattern, with one long hold-off to back the block up
   // ---------------------------------------------------------------------------------------
   int   results_seen   = 0;
   int   fail_count     = 0;
   int   stall_pct      = 0;
   int   pattern_left   = 0;
   int   hold_left      = 0;
   logic long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_pct    = 25 * $urandom_range(0, 3);
            pattern_left = $urandom_range(16, 96);
         end else begin
            pattern_left--;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: compare each result transaction with the oldest awaited one
   // ---------------------------------------------------------------------------------------
   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch at result %0d: expected %0h, got %0h",
                field, results_seen, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (awaited_results.size() == 0) begin
            $error("unawaited result %0d: kind %0d data %0h code %0d end %0b", results_seen,
                   rsp_result_kind, rsp_data_byte, rsp_error_code, rsp_run_end);
            fail_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("result_kind", 8'(want.result_kind), 8'(rsp_result_kind));
            check_field("data_byte", want.data_byte, rsp_data_byte);
            check_field("error_code", 8'(want.error_code), 8'(rsp_error_code));
            check_field("run_end", 8'(want.run_end), 8'(rsp_run_end));
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------------------------
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited",
                  cycle_count, awaited_results.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Build the patch, release reset, wait for the run to drain
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [7:0]     body[$];
      logic [7:0]     odd_kind;
      patch_item_type item;
      ending_type     ending;
      flavor_type     flavor;
      logic [7:0]     closing_kind;
      int             decl_old;
      int             decl_new;
      int             pick;

      pick   = $urandom_range(0, 9);
      flavor = (pick < 7) ? FLAVOR_MIXED : (pick < 9) ? FLAVOR_ADD : FLAVOR_DELETE;
      ending = ending_type'($urandom_range(0, 7));
      closing_kind = (flavor == FLAVOR_ADD) ? CH_PLUS :
                     (flavor == FLAVOR_DELETE) ? CH_DASH : CH_SPACE;

      // directed opening: extreme content bytes on a context and a removed line, one empty added line
      if (flavor == FLAVOR_MIXED) begin
         patch_text = '{CH_SPACE, 8'h00, 8'hFF, CH_NL, CH_DASH, 8'h80, 8'h7F, CH_NL,
                        CH_PLUS, CH_NL};
         old_line_total = 2;
         new_line_total = 2;
      end

      // random body lines
      while (patch_text.size() < BODY_BYTES) begin
         case (flavor)
            FLAVOR_ADD:    put_line(CH_PLUS, line_length());
            FLAVOR_DELETE: put_line(CH_DASH, line_length());
            default: begin
               pick = $urandom_range(0, 2);
               put_line((pick == 0) ? CH_DASH : (pick == 1) ? CH_PLUS : CH_SPACE,
                        line_length());
            end
         endcase
      end

      // tail that decides how the run ends
      case (ending)
         END_MARKERS: begin
            if (flavor != FLAVOR_ADD) begin
               put_line(CH_DASH, line_length());
               put_text(MARKER_TEXT);
            end
            if (flavor != FLAVOR_DELETE) begin
               put_line(CH_PLUS, line_length());
               put_text(MARKER_TEXT);
            end
         end
         END_OVERLONG: put_line(closing_kind, line_length());
         END_UNTERMINATED: begin
            patch_text.push_back(closing_kind);
            repeat ($urandom_range(0, 5)) patch_text.push_back(plain_byte());
         end
         END_BAD_KIND: begin
            do odd_kind = 8'($urandom_range(0, 255));
            while (odd_kind == CH_DASH || odd_kind == CH_PLUS || odd_kind == CH_SPACE ||
                   odd_kind == CH_BSLASH);
            patch_text.push_back(odd_kind);
            patch_text.push_back(plain_byte());
            patch_text.push_back(CH_NL);
         end
         END_MISPLACED: begin
            put_line(closing_kind, line_length());
            put_text(MARKER_TEXT);
            put_text(MARKER_TEXT);
         end
         END_AFTER_MARKER: begin
            odd_kind = (flavor == FLAVOR_ADD) ? CH_PLUS : CH_DASH;
            put_line(odd_kind, line_length());
            put_text(MARKER_TEXT);
            put_line(odd_kind, line_length());
         end
         default: ;
      endcase

      // declared counts, off by one where the ending needs it
      decl_old = old_line_total;
      decl_new = new_line_total;
      if (ending == END_TRUNCATED) begin
         if (flavor == FLAVOR_ADD || (flavor == FLAVOR_MIXED && $urandom_range(0, 1) == 1))
            decl_new++;
         else
            decl_old++;
      end else if (ending == END_OVERLONG) begin
         if (flavor == FLAVOR_ADD || (flavor == FLAVOR_MIXED && $urandom_range(0, 1) == 1))
            decl_new--;
         else
            decl_old--;
      end

      // headers go in front of the body
      body = patch_text;
      patch_text.delete();
      put_text(MINUS_TEXT);
      patch_text.push_back(8'h00);
      patch_text.push_back(8'hFF);
      repeat ($urandom_range(0, 8)) patch_text.push_back(plain_byte());
      patch_text.push_back(CH_NL);
      put_text(PLUS_TEXT);
      repeat ($urandom_range(0, 8)) patch_text.push_back(plain_byte());
      patch_text.push_back(CH_NL);
      put_text(HUNK_TEXT);
      put_range(decl_old);
      put_text(MID_TEXT);
      put_range(decl_new);
      put_text(TAIL_TEXT);
      foreach (body[i]) patch_text.push_back(body[i]);

      foreach (patch_text[i]) begin
         item.patch_byte = patch_text[i];
         item.last_byte  = (i == patch_text.size() - 1);
         patch_bytes_q.push_back(item);
      end
      // bytes after the run has stopped must produce nothing
      repeat (TRAIL_ITEMS) begin
         item.patch_byte = 8'($urandom_range(0, 255));
         item.last_byte  = 1'($urandom_range(0, 1));
         patch_bytes_q.push_back(item);
      end
      drain_at = $urandom_range(400, patch_text.size() - 200);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (patch_bytes_q.size() != 0 || req_valid) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Streamed %0d patch bytes: %s body, %s ending, %0d results checked",
               bytes_accepted, flavor.name(), ending.name(), results_seen);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/uhp_pkg.sv
rtl/uhp_core.sv
rtl/uhp_rsp_fifo.sv
rtl/unified_hunk_parser.sv
test/tb_unified_hunk_parser.sv
